// ===== rtl/sts_pkg.sv =====
`default_nettype none

package sts_pkg;

   localparam int PosWidth     = 16;
   localparam int KeywordChars = 8;
   localparam int KeywordCount = 33;
   localparam int TypeWidth    = 6;
   localparam int MaxResults   = 3;

   localparam logic [TypeWidth-1:0] TokIdent   = 6'd0;
   localparam logic [TypeWidth-1:0] TokString  = 6'd1;
   localparam logic [TypeWidth-1:0] TokInt     = 6'd2;
   localparam logic [TypeWidth-1:0] TokKw0     = 6'd3;
   localparam logic [TypeWidth-1:0] TokEq      = 6'd36;
   localparam logic [TypeWidth-1:0] TokLt      = 6'd37;
   localparam logic [TypeWidth-1:0] TokLe      = 6'd38;
   localparam logic [TypeWidth-1:0] TokGt      = 6'd39;
   localparam logic [TypeWidth-1:0] TokGe      = 6'd40;
   localparam logic [TypeWidth-1:0] TokNe      = 6'd41;
   localparam logic [TypeWidth-1:0] TokDot     = 6'd42;
   localparam logic [TypeWidth-1:0] TokComma   = 6'd43;
   localparam logic [TypeWidth-1:0] TokSemi    = 6'd44;
   localparam logic [TypeWidth-1:0] TokLParen  = 6'd45;
   localparam logic [TypeWidth-1:0] TokRParen  = 6'd46;
   localparam logic [TypeWidth-1:0] TokStar    = 6'd47;
   localparam logic [TypeWidth-1:0] TokPlus    = 6'd48;
   localparam logic [TypeWidth-1:0] TokMinus   = 6'd49;
   localparam logic [TypeWidth-1:0] TokSlash   = 6'd50;
   localparam logic [TypeWidth-1:0] TokUnknown = 6'd51;
   localparam logic [TypeWidth-1:0] TokEnd     = 6'd52;

   localparam logic [8*KeywordChars-1:0] KwTable [KeywordCount] = '{
      64'("SELECT"), 64'("INSERT"), 64'("UPDATE"), 64'("DELETE"), 64'("CREATE"),
      64'("DROP"), 64'("TABLE"), 64'("FROM"), 64'("WHERE"), 64'("INTO"),
      64'("VALUES"), 64'("SET"), 64'("AND"), 64'("OR"), 64'("NOT"), 64'("INT"),
      64'("VARCHAR"), 64'("PRIMARY"), 64'("KEY"), 64'("INDEX"), 64'("ON"),
      64'("BEGIN"), 64'("COMMIT"), 64'("ROLLBACK"), 64'("COUNT"), 64'("SUM"),
      64'("AVG"), 64'("MAX"), 64'("MIN"), 64'("JOIN"), 64'("INNER"),
      64'("LEFT"), 64'("RIGHT")
   };

   typedef struct packed {
      logic [TypeWidth-1:0] token_type;
      logic [PosWidth-1:0]  start_pos;
      logic [PosWidth-1:0]  value_len;
      logic [PosWidth-1:0]  line_no;
      logic                 last_of_run;
   } result_type;

   function automatic logic [PosWidth-1:0] sat_inc(input logic [PosWidth-1:0] v);
      return (&v) ? v : v + PosWidth'(1);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
   endfunction

   function automatic logic [TypeWidth-1:0] single_op(input logic [7:0] c);
      logic [TypeWidth-1:0] t;
      case (c)
         8'h2E:   t = TokDot;
         8'h2C:   t = TokComma;
         8'h3B:   t = TokSemi;
         8'h28:   t = TokLParen;
         8'h29:   t = TokRParen;
         8'h2A:   t = TokStar;
         8'h2B:   t = TokPlus;
         8'h2D:   t = TokMinus;
         8'h2F:   t = TokSlash;
         default: t = TokUnknown;
      endcase
      return t;
   endfunction

   function automatic logic [TypeWidth-1:0] word_type(
      input logic [8*KeywordChars-1:0] word,
      input logic [PosWidth-1:0]       len
   );
      logic [TypeWidth-1:0] t;
      t = TokIdent;
      if (len <= PosWidth'(KeywordChars)) begin
         for (int i = 0; i < KeywordCount; i++) begin
            if (KwTable[i] == word) begin
               t = TokKw0 + TypeWidth'(i);
            end
         end
      end
      return t;
   endfunction

   function automatic result_type make_result(
      input logic [TypeWidth-1:0] t,
      input logic [PosWidth-1:0]  start,
      input logic [PosWidth-1:0]  len,
      input logic [PosWidth-1:0]  line
   );
      result_type r;
      r.token_type  = t;
      r.start_pos   = start;
      r.value_len   = len;
      r.line_no     = line;
      r.last_of_run = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sql_token_scanner.sv =====
// Lexes SQL text arriving one byte per transfer, tlast marking the last byte of a query, and
// emits one transfer per token with its type, start offset, length and ending line; the
// last token caused by a byte carries tlast, and the final byte is followed by an end token
// after which offsets and line count start over. Each byte is classified in the cycle it is
// accepted and its zero to three tokens are written into a four-entry result queue that
// drains one token per cycle while the output is ready, so a byte that yields at most one
// token can be taken every cycle while the output keeps pace, and a byte that yields more
// can hold off the next byte; the input is taken whenever the queue holds at most one token.
`default_nettype none

module sql_token_scanner
   import sts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   input  wire logic        req_tlast,   // final_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [5:0] token_type, [21:6] start_pos, [37:22] value_len, [53:38] line_no, [55:54] zero
   output      logic [55:0] rsp_tdata,
   output      logic        rsp_tlast    // last_of_run
);

   localparam int FifoDepth = 4;
   localparam int PtrWidth  = $clog2(FifoDepth);
   localparam int CntWidth  = $clog2(FifoDepth + 1);

   localparam logic [7:0] ChQuote   = 8'h27;
   localparam logic [7:0] ChUnder   = 8'h5F;
   localparam logic [7:0] ChLess    = 8'h3C;
   localparam logic [7:0] ChGreater = 8'h3E;
   localparam logic [7:0] ChBang    = 8'h21;
   localparam logic [7:0] ChEqual   = 8'h3D;
   localparam logic [7:0] ChNewline = 8'h0A;

   typedef enum logic [2:0] {
      ModeIdle, ModeStr, ModeNum, ModeWord, ModeLt, ModeGt, ModeBang
   } mode_type;

   mode_type                    mode_ff, mode_in;
   logic [8*KeywordChars-1:0]   wbuf_ff, wbuf_in;
   logic [PosWidth-1:0]         start_ff, start_in;
   logic [PosWidth-1:0]         len_ff, len_in;
   logic [PosWidth-1:0]         pos_ff, pos_in;
   logic [PosWidth-1:0]         line_ff, line_in;

   result_type                  fifo_ff [FifoDepth];
   logic [PtrWidth-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]         cnt_ff, cnt_in;

   result_type                  res_a, res_b, res_c;
   logic                        va, vb, vc;
   logic                        used;
   logic                        push, pop;
   logic [PtrWidth-1:0]         idx_b, idx_c;
   logic [7:0]                  ch;
   logic                        fin;
   result_type                  head;

   assign ch  = req_tdata;
   assign fin = req_tlast;

   always_comb begin
      mode_in  = mode_ff;
      wbuf_in  = wbuf_ff;
      start_in = start_ff;
      len_in   = len_ff;
      used     = 1'b0;
      va       = 1'b0;
      vb       = 1'b0;
      vc       = 1'b0;
      res_a    = make_result(TokIdent, '0, '0, '0);
      res_b    = res_a;
      res_c    = res_a;

      case (mode_ff)
         ModeStr: begin
            used = 1'b1;
            if (ch == ChQuote) begin
               va      = 1'b1;
               res_a   = make_result(TokString, start_ff, len_ff, line_ff);
               mode_in = ModeIdle;
            end else begin
               len_in = sat_inc(len_ff);
            end
         end
         ModeNum: begin
            if (is_digit(ch)) begin
               used   = 1'b1;
               len_in = sat_inc(len_ff);
            end else begin
               va      = 1'b1;
               res_a   = make_result(TokInt, start_ff, len_ff, line_ff);
               mode_in = ModeIdle;
            end
         end
         ModeWord: begin
            if (is_alpha(ch) || is_digit(ch) || ch == ChUnder) begin
               used    = 1'b1;
               len_in  = sat_inc(len_ff);
               wbuf_in = {wbuf_ff[8*KeywordChars-9:0], to_upper(ch)};
            end else begin
               va      = 1'b1;
               res_a   = make_result(word_type(wbuf_ff, len_ff), start_ff, len_ff, line_ff);
               mode_in = ModeIdle;
            end
         end
         ModeLt, ModeGt, ModeBang: begin
            va      = 1'b1;
            mode_in = ModeIdle;
            if (ch == ChEqual) begin
               used  = 1'b1;
               res_a = make_result((mode_ff == ModeLt) ? TokLe :
                                   (mode_ff == ModeGt) ? TokGe : TokNe,
                                   start_ff, PosWidth'(2), line_ff);
            end else begin
               res_a = make_result((mode_ff == ModeLt) ? TokLt :
                                   (mode_ff == ModeGt) ? TokGt : TokUnknown,
                                   start_ff, PosWidth'(1), line_ff);
            end
         end
         default: begin
            mode_in = ModeIdle;
         end
      endcase

      if (!used && !is_space(ch)) begin
         start_in = pos_ff;
         if (ch == ChQuote) begin
            mode_in  = ModeStr;
            start_in = sat_inc(pos_ff);
            len_in   = '0;
         end else if (is_digit(ch)) begin
            mode_in = ModeNum;
            len_in  = PosWidth'(1);
         end else if (is_alpha(ch) || ch == ChUnder) begin
            mode_in = ModeWord;
            len_in  = PosWidth'(1);
            wbuf_in = {{(8*KeywordChars-8){1'b0}}, to_upper(ch)};
         end else if (ch == ChLess) begin
            mode_in = ModeLt;
         end else if (ch == ChGreater) begin
            mode_in = ModeGt;
         end else if (ch == ChBang) begin
            mode_in = ModeBang;
         end else if (ch == ChEqual) begin
            vb    = 1'b1;
            res_b = make_result(TokEq, pos_ff, PosWidth'(1), line_ff);
         end else begin
            vb    = 1'b1;
            res_b = make_result(single_op(ch), pos_ff, PosWidth'(1), line_ff);
         end
      end

      line_in = (ch == ChNewline) ? sat_inc(line_ff) : line_ff;
      pos_in  = sat_inc(pos_ff);

      if (fin) begin
         case (mode_in)
            ModeStr: begin
               vb    = 1'b1;
               res_b = make_result(TokString, start_in, len_in, line_in);
            end
            ModeNum: begin
               vb    = 1'b1;
               res_b = make_result(TokInt, start_in, len_in, line_in);
            end
            ModeWord: begin
               vb    = 1'b1;
               res_b = make_result(word_type(wbuf_in, len_in), start_in, len_in, line_in);
            end
            ModeLt: begin
               vb    = 1'b1;
               res_b = make_result(TokLt, start_in, PosWidth'(1), line_in);
            end
            ModeGt: begin
               vb    = 1'b1;
               res_b = make_result(TokGt, start_in, PosWidth'(1), line_in);
            end
            ModeBang: begin
               vb    = 1'b1;
               res_b = make_result(TokUnknown, start_in, PosWidth'(1), line_in);
            end
            default: begin
            end
         endcase
         vc       = 1'b1;
         res_c    = make_result(TokEnd, pos_in, '0, line_in);
         mode_in  = ModeIdle;
         wbuf_in  = '0;
         start_in = '0;
         len_in   = '0;
         pos_in   = '0;
         line_in  = PosWidth'(1);
      end

      res_a.last_of_run = va && !vb && !vc;
      res_b.last_of_run = vb && !vc;
      res_c.last_of_run = vc;
   end

   assign req_tready = cnt_ff <= CntWidth'(FifoDepth - MaxResults);
   assign push       = req_tvalid && req_tready;
   assign rsp_tvalid = cnt_ff != '0;
   assign pop        = rsp_tvalid && rsp_tready;

   assign idx_b = wr_ptr_ff + PtrWidth'(va);
   assign idx_c = idx_b + PtrWidth'(vb);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      cnt_in    = cnt_ff - CntWidth'(pop);
      if (push) begin
         wr_ptr_in = idx_c + PtrWidth'(vc);
         cnt_in    = cnt_in + CntWidth'(va) + CntWidth'(vb) + CntWidth'(vc);
      end
      rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ModeIdle;
         wbuf_ff   <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         pos_ff    <= '0;
         line_ff   <= PosWidth'(1);
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            mode_ff  <= mode_in;
            wbuf_ff  <= wbuf_in;
            start_ff <= start_in;
            len_ff   <= len_in;
            pos_ff   <= pos_in;
            line_ff  <= line_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         if (va) begin
            fifo_ff[wr_ptr_ff] <= res_a;
         end
         if (vb) begin
            fifo_ff[idx_b] <= res_b;
         end
         if (vc) begin
            fifo_ff[idx_c] <= res_c;
         end
      end
   end

   assign head      = fifo_ff[rd_ptr_ff];
   assign rsp_tdata = {2'b00, head.line_no, head.value_len, head.start_pos, head.token_type};
   assign rsp_tlast = head.last_of_run;

endmodule

`default_nettype wire

// ===== rtl/sts_checker.sv =====
`default_nettype none

module sts_checker
   import sts_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   logic [TypeWidth-1:0] token_type;
   logic [PosWidth-1:0]  value_len;
   logic [PosWidth-1:0]  line_no;

   assign token_type = rsp_tdata[5:0];
   assign value_len  = rsp_tdata[37:22];
   assign line_no    = rsp_tdata[53:38];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_end_token: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && token_type == TokEnd |-> rsp_tlast && value_len == '0)
      else $error("end token malformed");

   a_type_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> token_type <= TokEnd && line_no != '0)
      else $error("token type or line number out of range");

   a_pair_ops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (token_type == TokLe || token_type == TokGe || token_type == TokNe)
      |-> value_len == PosWidth'(2))
      else $error("two-byte operator with wrong length");

endmodule

bind sql_token_scanner sts_checker u_sts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
